### design/assert_macros.svh
// Assertion macros for the line follower drive block.
// Included by the top level; compiled to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property check, disabled while in reset.
`define LFPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
// Expression must never be true at a clock edge outside reset.
`define LFPD_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);
`else
`define LFPD_ASSERT(label, clk, rst, prop, msg)
`define LFPD_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

### design/lfpd_pkg.sv
// Shared types, widths, codes and tables of the line follower drive block.
// No dependencies; every other file of the block but assert_macros.svh uses this package.
`default_nettype none

package lfpd_pkg;

   // frame geometry
   localparam int SENSOR_COUNT = 8;
   localparam int SENSOR_IDX_W = $clog2(SENSOR_COUNT);
   localparam int CNT_W        = $clog2(SENSOR_COUNT + 1);
   localparam int IDX_SUM_W    = $clog2(SENSOR_COUNT * (SENSOR_COUNT - 1) / 2 + 1);
   localparam int CMP_W        = IDX_SUM_W + 1;
   localparam int LIT_MIN      = 3;
   localparam int SENSE_W      = 10;
   localparam int SENSE_FULL   = 1000;
   localparam int POS_W        = 13;
   localparam int CENTRE_POS   = 3500;

   // controller arithmetic
   localparam int ERR_W    = 13;
   localparam int DIFF_W   = ERR_W + 1;
   localparam int SUM_W    = 32;
   localparam int GAIN_W   = 8;
   localparam int EXP_W    = 3;
   localparam int DECADES  = 2 ** EXP_W;
   localparam int FRAC_W   = 16;
   localparam int DIV_W    = GAIN_W + FRAC_W;
   localparam int DIV_STEPS = 2;
   localparam int PROD_W   = DIV_W + 1 + SUM_W;
   localparam int ACC_W    = PROD_W + 1;
   localparam int CORR_W   = 10;
   localparam int SPD_W    = 12;
   localparam int PWM_W    = 8;

   // defaults of the top level parameters
   localparam int BASE_SPEED_DEF = 100;
   localparam int MAX_SPEED_DEF  = 150;
   localparam int MIN_SPEED_DEF  = -100;
   localparam int TURN_PWM_DEF   = 100;

   // result action codes
   localparam int ACTION_W = 2;
   localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DRIVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SPIN  = 2'd2;

   // gain term select
   localparam int GAIN_SEL_W = 2;
   localparam logic [GAIN_SEL_W-1:0] GAIN_P = 2'd0;
   localparam logic [GAIN_SEL_W-1:0] GAIN_I = 2'd1;
   localparam logic [GAIN_SEL_W-1:0] GAIN_D = 2'd2;

   // register port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PROP_EXP      = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_EXP     = 8'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN    = 8'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_EXP     = 8'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RUN_ENABLE    = 8'd6;
   localparam logic [CSR_IDX_W-1:0] REG_LIT_THRESHOLD = 8'd7;

   // powers of ten, divisor of each gain mantissa
   localparam logic [DIV_W-1:0] POW_TEN [DECADES] = '{
      24'd1, 24'd10, 24'd100, 24'd1000,
      24'd10000, 24'd100000, 24'd1000000, 24'd10000000
   };

   typedef struct packed {
      logic [POS_W-1:0]   line_position;
      logic [SENSE_W-1:0] sensor_0;
      logic [SENSE_W-1:0] sensor_1;
      logic [SENSE_W-1:0] sensor_2;
      logic [SENSE_W-1:0] sensor_3;
      logic [SENSE_W-1:0] sensor_4;
      logic [SENSE_W-1:0] sensor_5;
      logic [SENSE_W-1:0] sensor_6;
      logic [SENSE_W-1:0] sensor_7;
   } req_payload_type;

   typedef struct packed {
      logic                phase_a;
      logic                phase_b;
      logic [PWM_W-1:0]    pwm_a;
      logic [PWM_W-1:0]    pwm_b;
      logic [ACTION_W-1:0] action;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_payload_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  prop_gain;
      logic [EXP_W-1:0]   prop_exp;
      logic [GAIN_W-1:0]  integ_gain;
      logic [EXP_W-1:0]   integ_exp;
      logic [GAIN_W-1:0]  deriv_gain;
      logic [EXP_W-1:0]   deriv_exp;
      logic               run_enable;
      logic [SENSE_W-1:0] lit_threshold;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      prop_gain:     8'd0,
      prop_exp:      3'd1,
      integ_gain:    8'd0,
      integ_exp:     3'd1,
      deriv_gain:    8'd0,
      deriv_exp:     3'd1,
      run_enable:    1'b0,
      lit_threshold: 10'd500
   };

   // controller to datapath
   typedef struct packed {
      logic                  load;
      logic                  res_stop;
      logic                  res_spin;
      logic                  err_step;
      logic                  div_start;
      logic                  mul;
      logic                  acc_add;
      logic                  corr;
      logic                  res_drive;
      logic [GAIN_SEL_W-1:0] gain_sel;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic run;
      logic crossing;
      logic div_done;
   } dp_status_type;

endpackage

`default_nettype wire

### design/lfpd_if.sv
// Valid/ready channel interfaces of the line follower drive block.
// Depends on lfpd_pkg for the payload types.
`default_nettype none

interface lfpd_req_if;
   import lfpd_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lfpd_rsp_if;
   import lfpd_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lfpd_csr_if;
   import lfpd_pkg::*;
   logic            valid;
   logic            ready;
   csr_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/lfpd_div.sv
// Iterative restoring divider, DIV_STEPS quotient bits per cycle.
// Depends on lfpd_pkg for its default width and step count.
`default_nettype none

module lfpd_div #(
   parameter int WIDTH = lfpd_pkg::DIV_W,
   parameter int STEPS = lfpd_pkg::DIV_STEPS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);
   localparam int ITERS = WIDTH / STEPS;
   localparam int CNT_W = $clog2(ITERS + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] den_ff, den_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;
   logic [WIDTH-1:0] rem_v;
   logic [WIDTH-1:0] quo_v;

   // control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ITERS);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // datapath: STEPS restoring steps per cycle
   always_comb begin
      rem_v   = rem_ff;
      quo_v   = quo_ff;
      shifted = '0;
      diff    = '0;
      for (int j = 0; j < STEPS; j++) begin
         shifted = {rem_v, quo_v[WIDTH-1]};
         quo_v   = {quo_v[WIDTH-2:0], 1'b0};
         diff    = shifted - {1'b0, den_ff};
         if (!diff[WIDTH]) begin
            rem_v    = diff[WIDTH-1:0];
            quo_v[0] = 1'b1;
         end else begin
            rem_v = shifted[WIDTH-1:0];
         end
      end
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         den_in = divisor;
      end else if (busy_ff) begin
         rem_in = rem_v;
         quo_in = quo_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### design/lfpd_datapath.sv
// Datapath: frame register, crossing classifier, PID state, gain divider,
// shared multiplier, accumulator and speed mapping. Depends on lfpd_pkg, lfpd_div.
`default_nettype none

module lfpd_datapath #(
   parameter int BASE_SPEED = lfpd_pkg::BASE_SPEED_DEF,
   parameter int MAX_SPEED  = lfpd_pkg::MAX_SPEED_DEF,
   parameter int MIN_SPEED  = lfpd_pkg::MIN_SPEED_DEF,
   parameter int TURN_PWM   = lfpd_pkg::TURN_PWM_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lfpd_pkg::cfg_type         cfg,
   input  lfpd_pkg::req_payload_type frame,
   input  lfpd_pkg::dp_cmd_type      cmd,
   output lfpd_pkg::dp_status_type   status,
   output lfpd_pkg::rsp_payload_type result
);
   import lfpd_pkg::*;

   localparam logic signed [SPD_W-1:0] BASE_S = SPD_W'(BASE_SPEED);
   localparam logic signed [SPD_W-1:0] MAX_S  = SPD_W'(MAX_SPEED);
   localparam logic signed [SPD_W-1:0] MIN_S  = SPD_W'(MIN_SPEED);
   localparam logic [PWM_W-1:0]        PWM_TURN = PWM_W'(TURN_PWM);
   localparam int CW_W = ACC_W - FRAC_W;

   function automatic logic signed [SPD_W-1:0] clamp_speed(
      input logic signed [SPD_W-1:0] v
   );
      logic signed [SPD_W-1:0] r;
      r = v;
      if (r > MAX_S) r = MAX_S;
      if (r < MIN_S) r = MIN_S;
      return r;
   endfunction

   function automatic logic [PWM_W-1:0] magnitude(input logic signed [SPD_W-1:0] v);
      logic [SPD_W-1:0] m;
      m = v[SPD_W-1] ? SPD_W'(-v) : SPD_W'(v);
      return (m > SPD_W'({PWM_W{1'b1}})) ? {PWM_W{1'b1}} : m[PWM_W-1:0];
   endfunction

   req_payload_type              frame_ff, frame_in;
   logic [SENSE_W-1:0]           sens [SENSOR_COUNT];
   logic [CNT_W-1:0]             lit_count;
   logic [IDX_SUM_W-1:0]         idx_sum;
   logic [CMP_W-1:0]             lhs, rhs;
   logic [CNT_W-2:0]             half_win;
   logic [SENSE_W-1:0]           dark_val;
   logic [SENSOR_IDX_W-1:0]      dark_pos;
   logic                         spin_right;

   logic signed [ERR_W:0]        err_wide;
   logic signed [ERR_W-1:0]      err_sat;
   logic signed [SUM_W:0]        sum_wide;
   logic signed [SUM_W-1:0]      sum_sat;
   logic signed [DIFF_W-1:0]     diff_now;

   logic signed [ERR_W-1:0]      prev_error_ff, prev_error_in;
   logic signed [SUM_W-1:0]      error_sum_ff, error_sum_in;
   logic signed [ERR_W-1:0]      err_ff, err_in;
   logic signed [DIFF_W-1:0]     diff_ff, diff_in;
   logic signed [PROD_W-1:0]     product_ff, product_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic signed [CORR_W-1:0]     corr_ff, corr_in;
   rsp_payload_type              result_ff, result_in;

   logic [GAIN_W-1:0]            div_k;
   logic [EXP_W-1:0]             div_e;
   logic [DIV_W-1:0]             div_quot;
   logic                         div_done;
   logic signed [DIV_W:0]        mul_a;
   logic signed [SUM_W-1:0]      mul_b;
   logic signed [PROD_W-1:0]     product;

   logic                         round_up;
   logic signed [CW_W-1:0]       corr_wide;
   logic signed [CORR_W-1:0]     corr_sat;
   logic signed [SPD_W-1:0]      corr_ext;
   logic signed [SPD_W-1:0]      spd_a, spd_b;

   // crossing classification
   always_comb begin
      sens[0] = frame_ff.sensor_0;
      sens[1] = frame_ff.sensor_1;
      sens[2] = frame_ff.sensor_2;
      sens[3] = frame_ff.sensor_3;
      sens[4] = frame_ff.sensor_4;
      sens[5] = frame_ff.sensor_5;
      sens[6] = frame_ff.sensor_6;
      sens[7] = frame_ff.sensor_7;
   end

   always_comb begin
      lit_count = '0;
      idx_sum   = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (sens[i] >= cfg.lit_threshold) begin
            lit_count = lit_count + CNT_W'(1);
            idx_sum   = idx_sum + IDX_SUM_W'(i);
         end
      end
      lhs      = {idx_sum, 1'b0};
      rhs      = CMP_W'(SENSOR_COUNT - 1) * CMP_W'(lit_count);
      half_win = lit_count[CNT_W-1:1];
      // darkest sensor of the centre window, first strict minimum wins
      dark_val = SENSE_W'(SENSE_FULL);
      dark_pos = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if ((i + int'(half_win) >= SENSOR_COUNT / 2) &&
             (i < SENSOR_COUNT / 2 + int'(half_win)) && (sens[i] < dark_val)) begin
            dark_val = sens[i];
            dark_pos = SENSOR_IDX_W'(i);
         end
      end
      if (lhs < rhs) begin
         spin_right = 1'b1;
      end else if (lhs > rhs) begin
         spin_right = 1'b0;
      end else begin
         spin_right = dark_pos < SENSOR_IDX_W'(SENSOR_COUNT / 2);
      end
   end

   // error, saturating integral, difference
   always_comb begin
      err_wide = $signed((ERR_W + 1)'(CENTRE_POS)) - $signed({1'b0, frame_ff.line_position});
      if (err_wide[ERR_W] != err_wide[ERR_W-1]) begin
         err_sat = err_wide[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
      end else begin
         err_sat = err_wide[ERR_W-1:0];
      end
      sum_wide = {error_sum_ff[SUM_W-1], error_sum_ff}
               + {{(SUM_W-ERR_W+1){err_sat[ERR_W-1]}}, err_sat};
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
      diff_now = {err_sat[ERR_W-1], err_sat} - {prev_error_ff[ERR_W-1], prev_error_ff};
   end

   // gain term select
   always_comb begin
      case (cmd.gain_sel)
         GAIN_P: begin
            div_k = cfg.prop_gain;
            div_e = cfg.prop_exp;
            mul_b = {{(SUM_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
         end
         GAIN_I: begin
            div_k = cfg.integ_gain;
            div_e = cfg.integ_exp;
            mul_b = error_sum_ff;
         end
         GAIN_D: begin
            div_k = cfg.deriv_gain;
            div_e = cfg.deriv_exp;
            mul_b = {{(SUM_W-DIFF_W){diff_ff[DIFF_W-1]}}, diff_ff};
         end
         default: begin
            div_k = '0;
            div_e = '0;
            mul_b = '0;
         end
      endcase
      mul_a   = $signed({1'b0, div_quot});
      product = mul_a * mul_b;
   end

   lfpd_div #(
      .WIDTH (DIV_W),
      .STEPS (DIV_STEPS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({div_k, {FRAC_W{1'b0}}}),
      .divisor  (POW_TEN[div_e]),
      .done     (div_done),
      .quotient (div_quot)
   );

   // correction: truncate toward zero, then saturate; speeds clamp either way
   always_comb begin
      round_up  = acc_ff[ACC_W-1] & (|acc_ff[FRAC_W-1:0]);
      corr_wide = $signed(acc_ff[ACC_W-1:FRAC_W]) + $signed({{(CW_W-1){1'b0}}, round_up});
      if ((&corr_wide[CW_W-1:CORR_W-1]) || !(|corr_wide[CW_W-1:CORR_W-1])) begin
         corr_sat = corr_wide[CORR_W-1:0];
      end else begin
         corr_sat = corr_wide[CW_W-1] ? {1'b1, {(CORR_W-1){1'b0}}}
                                      : {1'b0, {(CORR_W-1){1'b1}}};
      end
      corr_ext = {{(SPD_W-CORR_W){corr_ff[CORR_W-1]}}, corr_ff};
      spd_a    = clamp_speed(BASE_S + corr_ext);
      spd_b    = clamp_speed(BASE_S - corr_ext);
   end

   // next state
   always_comb begin
      frame_in      = frame_ff;
      prev_error_in = prev_error_ff;
      error_sum_in  = error_sum_ff;
      err_in        = err_ff;
      diff_in       = diff_ff;
      product_in    = product_ff;
      acc_in        = acc_ff;
      corr_in       = corr_ff;
      result_in     = result_ff;
      if (cmd.load) frame_in = frame;
      if (cmd.err_step) begin
         prev_error_in = err_sat;
         error_sum_in  = sum_sat;
         err_in        = err_sat;
         diff_in       = diff_now;
         acc_in        = '0;
      end
      if (cmd.mul) product_in = product;
      if (cmd.acc_add) begin
         acc_in = acc_ff + {{(ACC_W-PROD_W){product_ff[PROD_W-1]}}, product_ff};
      end
      if (cmd.corr) corr_in = corr_sat;
      if (cmd.res_stop) begin
         result_in.phase_a = 1'b0;
         result_in.phase_b = 1'b1;
         result_in.pwm_a   = '0;
         result_in.pwm_b   = '0;
         result_in.action  = ACT_STOP;
      end
      if (cmd.res_spin) begin
         result_in.phase_a = spin_right;
         result_in.phase_b = spin_right;
         result_in.pwm_a   = PWM_TURN;
         result_in.pwm_b   = PWM_TURN;
         result_in.action  = ACT_SPIN;
      end
      if (cmd.res_drive) begin
         result_in.phase_a = spd_a[SPD_W-1];
         result_in.phase_b = !spd_b[SPD_W-1];
         result_in.pwm_a   = magnitude(spd_a);
         result_in.pwm_b   = magnitude(spd_b);
         result_in.action  = ACT_DRIVE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         error_sum_ff  <= '0;
      end else begin
         prev_error_ff <= prev_error_in;
         error_sum_ff  <= error_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff   <= frame_in;
      err_ff     <= err_in;
      diff_ff    <= diff_in;
      product_ff <= product_in;
      acc_ff     <= acc_in;
      corr_ff    <= corr_in;
      result_ff  <= result_in;
   end

   assign status.run      = cfg.run_enable;
   assign status.crossing = lit_count >= CNT_W'(LIT_MIN);
   assign status.div_done = div_done;
   assign result          = result_ff;

endmodule

`default_nettype wire

### design/lfpd_ctrl.sv
// Sequencing state machine: frame accept, classify, three gain terms, emit.
// Depends on lfpd_pkg for the command and status structs.
`default_nettype none

module lfpd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    out_free,
   input  lfpd_pkg::dp_status_type status,
   output lfpd_pkg::dp_cmd_type    cmd,
   output logic                    req_ready,
   output logic                    emit
);
   import lfpd_pkg::*;

   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] S_IDLE     = 4'd0;
   localparam logic [STATE_W-1:0] S_CLASSIFY = 4'd1;
   localparam logic [STATE_W-1:0] S_START    = 4'd2;
   localparam logic [STATE_W-1:0] S_DIV      = 4'd3;
   localparam logic [STATE_W-1:0] S_MUL      = 4'd4;
   localparam logic [STATE_W-1:0] S_ACC      = 4'd5;
   localparam logic [STATE_W-1:0] S_CORR     = 4'd6;
   localparam logic [STATE_W-1:0] S_DRIVE    = 4'd7;
   localparam logic [STATE_W-1:0] S_EMIT     = 4'd8;

   logic [STATE_W-1:0]    state_ff, state_in;
   logic [GAIN_SEL_W-1:0] sel_ff, sel_in;

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      cmd       = '0;
      req_ready = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CLASSIFY;
            end
         end
         S_CLASSIFY: begin
            if (!status.run) begin
               cmd.res_stop = 1'b1;
               state_in     = S_EMIT;
            end else if (status.crossing) begin
               cmd.res_spin = 1'b1;
               state_in     = S_EMIT;
            end else begin
               cmd.err_step = 1'b1;
               sel_in       = GAIN_P;
               state_in     = S_START;
            end
         end
         S_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc_add = 1'b1;
            if (sel_ff == GAIN_D) begin
               state_in = S_CORR;
            end else begin
               sel_in   = sel_ff + GAIN_SEL_W'(1);
               state_in = S_START;
            end
         end
         S_CORR: begin
            cmd.corr = 1'b1;
            state_in = S_DRIVE;
         end
         S_DRIVE: begin
            cmd.res_drive = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      cmd.gain_sel = sel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= GAIN_P;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

`default_nettype wire

### design/line_follow_pid_drive.sv
// Channel   Dir  Handshake    Payload
// req_if    in   valid/ready  line_position, sensor_0 .. sensor_7
// rsp_if    out  valid/ready  phase_a, phase_b, pwm_a, pwm_b, action
// csr_if    in   valid/ready  index, data (register write, always ready)
//
// Top level of the PID line follower drive: register file, controller,
// datapath and output register. Depends on lfpd_pkg, lfpd_if, lfpd_ctrl,
// lfpd_datapath and assert_macros.svh.
//
// Sequencing: one frame at a time. A stopped or crossing frame goes from
//   classify straight to emit; a PID frame runs the gain divider
//   (12 iterations at two quotient bits a cycle, then a registered done flag)
//   once for each of the three terms, with a start, a multiply and
//   an accumulate state per term.
// Reset: synchronous, active high; clears the sequencer, the output valid,
//   the registers to their documented values and the PID state.
// Stalls: the output register holds a finished result while the next frame is
//   taken and worked on; the sequencer waits only to hand over a new result.
`default_nettype none
`include "assert_macros.svh"

module line_follow_pid_drive #(
   parameter int BASE_SPEED = lfpd_pkg::BASE_SPEED_DEF,
   parameter int MAX_SPEED  = lfpd_pkg::MAX_SPEED_DEF,
   parameter int MIN_SPEED  = lfpd_pkg::MIN_SPEED_DEF,
   parameter int TURN_PWM   = lfpd_pkg::TURN_PWM_DEF
) (
   input  logic  clock,
   input  logic  reset,
   lfpd_req_if.sink   req_if,
   lfpd_rsp_if.source rsp_if,
   lfpd_csr_if.sink   csr_if
);
   import lfpd_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   dp_cmd_type      cmd;
   dp_status_type   status;
   rsp_payload_type result;
   logic            req_ready;
   logic            emit;
   logic            out_free;

   // register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.payload.index)
            REG_PROP_GAIN:     cfg_in.prop_gain     = csr_if.payload.data[GAIN_W-1:0];
            REG_PROP_EXP:      cfg_in.prop_exp      = csr_if.payload.data[EXP_W-1:0];
            REG_INTEG_GAIN:    cfg_in.integ_gain    = csr_if.payload.data[GAIN_W-1:0];
            REG_INTEG_EXP:     cfg_in.integ_exp     = csr_if.payload.data[EXP_W-1:0];
            REG_DERIV_GAIN:    cfg_in.deriv_gain    = csr_if.payload.data[GAIN_W-1:0];
            REG_DERIV_EXP:     cfg_in.deriv_exp     = csr_if.payload.data[EXP_W-1:0];
            REG_RUN_ENABLE:    cfg_in.run_enable    = csr_if.payload.data[0];
            REG_LIT_THRESHOLD: cfg_in.lit_threshold = csr_if.payload.data[SENSE_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_if.ready = 1'b1;

   // sequencer
   lfpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .out_free  (out_free),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready),
      .emit      (emit)
   );

   // arithmetic and classification
   lfpd_datapath #(
      .BASE_SPEED (BASE_SPEED),
      .MAX_SPEED  (MAX_SPEED),
      .MIN_SPEED  (MIN_SPEED),
      .TURN_PWM   (TURN_PWM)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .frame  (req_if.payload),
      .cmd    (cmd),
      .status (status),
      .result (result)
   );

   assign req_if.ready = req_ready;

   // output register: free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = result;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload_ff;

   // one frame in flight: no second transaction straight after the first
   `LFPD_ASSERT(a_single_frame, clock, reset, req_if.valid && req_if.ready |=> !req_if.ready, "frame accepted while another is in flight")
   // a new result never overwrites one that has not been taken
   `LFPD_ASSERT_NEVER(a_no_overwrite, clock, reset, emit && rsp_valid_ff && !rsp_if.ready, "result overwritten before transaction")
   // a stopped result drives both motors to zero
   `LFPD_ASSERT(a_stop_quiet, clock, reset, rsp_valid_ff && rsp_payload_ff.action == ACT_STOP |-> rsp_payload_ff.pwm_a == 8'd0 && rsp_payload_ff.pwm_b == 8'd0 && rsp_payload_ff.phase_b, "stopped result with motor drive")

endmodule

`default_nettype wire
